// ===== rtl/mbq_pkg.sv =====
// Package for the multichannel biquad: sizes, register indexes, controller
// states and the command and status structs shared by the controller and datapath.
// No dependencies.
package mbq_pkg;

  // Block configuration.
  localparam int CHANNELS       = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 27;

  // Fixed field and register widths.
  localparam int CHAN_BITS  = 3;
  localparam int STATE_BITS = 32;
  localparam int COEF_BITS  = 32;
  localparam int B1_BITS    = 29;
  localparam int B2_BITS    = 28;
  localparam int REG_BITS   = 3;
  localparam int PROD_BITS  = 2 * COEF_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;
  localparam int IDX_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Stream widths, rounded up to whole bytes.
  localparam int IN_DATA_BITS  = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8;

  // Reset value of coef_a0: 1.0 in Q4.27.
  localparam logic signed [COEF_BITS-1:0] A0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;
  // Half an output LSB, added before the floor shift to round half up.
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

  // Configuration register indexes.
  localparam logic [REG_BITS-1:0] REG_A0 = 3'd0;
  localparam logic [REG_BITS-1:0] REG_A1 = 3'd1;
  localparam logic [REG_BITS-1:0] REG_A2 = 3'd2;
  localparam logic [REG_BITS-1:0] REG_B1 = 3'd3;
  localparam logic [REG_BITS-1:0] REG_B2 = 3'd4;

  // Item kinds carried on the input tuser.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB1,
    ST_FB2,
    ST_FF1,
    ST_FF2,
    ST_FF0,
    ST_SUM,
    ST_DONE
  } state_e;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_B1W1,
    MUL_B2W2,
    MUL_A1W1,
    MUL_A2W2,
    MUL_A0W
  } mul_sel_e;

  typedef struct packed {
    logic     load;     // capture the input beat and read the channel state
    logic     mul_en;   // register a new product
    mul_sel_e mul_sel;
    logic     fb_init;  // feedback sum := half + product
    logic     fb_add;   // feedback sum += product
    logic     w_load;   // form and saturate the new delay word
    logic     ff_init;  // output sum := half + product
    logic     ff_add;   // output sum += product
    logic     finish;   // update channel state and load the output register
  } cmd_t;

  typedef struct packed {
    logic op_clear;   // the captured item is a clear
    logic out_stall;  // output register holds a beat that is not taken this cycle
  } sts_t;

endpackage

// ===== rtl/mbq_ctrl.sv =====
// Controller for the multichannel biquad: sequences the shared multiplier and
// the two accumulators of the datapath. Depends on mbq_pkg.
module mbq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mbq_pkg::sts_t sts_i,
  output mbq_pkg::cmd_t cmd_o
);

  mbq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.mul_sel  = mbq_pkg::MUL_B1W1;
    case (state_q)
      mbq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mbq_pkg::ST_FB1;
        end
      end
      mbq_pkg::ST_FB1: begin
        // A clear needs no arithmetic.
        if (sts_i.op_clear) begin
          state_d = mbq_pkg::ST_DONE;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = mbq_pkg::MUL_B1W1;
          state_d       = mbq_pkg::ST_FB2;
        end
      end
      mbq_pkg::ST_FB2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mbq_pkg::MUL_B2W2;
        cmd_o.fb_init = 1'b1;
        state_d       = mbq_pkg::ST_FF1;
      end
      mbq_pkg::ST_FF1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mbq_pkg::MUL_A1W1;
        cmd_o.fb_add  = 1'b1;
        state_d       = mbq_pkg::ST_FF2;
      end
      mbq_pkg::ST_FF2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mbq_pkg::MUL_A2W2;
        cmd_o.w_load  = 1'b1;
        cmd_o.ff_init = 1'b1;
        state_d       = mbq_pkg::ST_FF0;
      end
      mbq_pkg::ST_FF0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mbq_pkg::MUL_A0W;
        cmd_o.ff_add  = 1'b1;
        state_d       = mbq_pkg::ST_SUM;
      end
      mbq_pkg::ST_SUM: begin
        cmd_o.ff_add = 1'b1;
        state_d      = mbq_pkg::ST_DONE;
      end
      mbq_pkg::ST_DONE: begin
        if (!sts_i.out_stall) begin
          cmd_o.finish = 1'b1;
          state_d      = mbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mbq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mbq_datapath.sv =====
// Datapath for the multichannel biquad: coefficient registers, per-channel
// delay words, the shared multiplier, both accumulators and the output register.
// Depends on mbq_pkg.
module mbq_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mbq_pkg::cmd_t                         cmd_i,
  output mbq_pkg::sts_t                         sts_o,
  input  logic                                  op_i,
  input  logic [mbq_pkg::CHAN_BITS-1:0]         chan_i,
  input  logic signed [mbq_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                  cfg_we_i,
  input  logic [mbq_pkg::REG_BITS-1:0]          cfg_index_i,
  input  logic [mbq_pkg::COEF_BITS-1:0]         cfg_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mbq_pkg::CHAN_BITS-1:0]         out_chan_o,
  output logic signed [mbq_pkg::SAMPLE_BITS-1:0] out_sample_o
);

  localparam int AW = mbq_pkg::ACC_BITS;
  localparam int SW = mbq_pkg::STATE_BITS;
  localparam int YW = mbq_pkg::SAMPLE_BITS;
  localparam logic signed [AW-1:0] W_MAX = AW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [AW-1:0] W_MIN = ~W_MAX;
  localparam logic signed [AW-1:0] Y_MAX = AW'({1'b0, {(YW-1){1'b1}}});
  localparam logic signed [AW-1:0] Y_MIN = ~Y_MAX;

  // Coefficients.
  logic signed [mbq_pkg::COEF_BITS-1:0] coef_a0_q, coef_a1_q, coef_a2_q;
  logic signed [mbq_pkg::B1_BITS-1:0]   coef_b1_q;
  logic signed [mbq_pkg::B2_BITS-1:0]   coef_b2_q;

  // Per-channel delay words.
  logic signed [SW-1:0] delay_one_q [mbq_pkg::CHANNELS];
  logic signed [SW-1:0] delay_two_q [mbq_pkg::CHANNELS];

  // Item registers.
  logic                              op_q;
  logic [mbq_pkg::CHAN_BITS-1:0]     chan_q;
  logic signed [YW-1:0]              x_q;
  logic signed [SW-1:0]              w1_q, w2_q, w_q;
  logic signed [mbq_pkg::PROD_BITS-1:0] prod_q;
  logic signed [AW-1:0]              fb_q, ff_q;

  logic                              out_valid_q;
  logic [mbq_pkg::CHAN_BITS-1:0]     out_chan_q;
  logic signed [YW-1:0]              out_sample_q;

  logic [mbq_pkg::IDX_BITS-1:0]      in_idx, idx;
  logic                              in_range_in, in_range;
  logic signed [mbq_pkg::COEF_BITS-1:0] mul_a;
  logic signed [SW-1:0]              mul_b;
  logic signed [mbq_pkg::PROD_BITS-1:0] prod_d;
  logic signed [AW-1:0]              prod_ext, w_sum, y_sum;
  logic signed [SW-1:0]              w_d;
  logic signed [YW-1:0]              y_d;

  assign in_idx      = mbq_pkg::IDX_BITS'(chan_i);
  assign in_range_in = 32'(chan_i) < mbq_pkg::CHANNELS;
  assign idx         = mbq_pkg::IDX_BITS'(chan_q);
  assign in_range    = 32'(chan_q) < mbq_pkg::CHANNELS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a0_q <= mbq_pkg::A0_RESET;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mbq_pkg::REG_A0: coef_a0_q <= cfg_data_i;
        mbq_pkg::REG_A1: coef_a1_q <= cfg_data_i;
        mbq_pkg::REG_A2: coef_a2_q <= cfg_data_i;
        mbq_pkg::REG_B1: coef_b1_q <= cfg_data_i[mbq_pkg::B1_BITS-1:0];
        mbq_pkg::REG_B2: coef_b2_q <= cfg_data_i[mbq_pkg::B2_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier with its operand select.
  always_comb begin
    case (cmd_i.mul_sel)
      mbq_pkg::MUL_B1W1: begin
        mul_a = mbq_pkg::COEF_BITS'(coef_b1_q);
        mul_b = w1_q;
      end
      mbq_pkg::MUL_B2W2: begin
        mul_a = mbq_pkg::COEF_BITS'(coef_b2_q);
        mul_b = w2_q;
      end
      mbq_pkg::MUL_A1W1: begin
        mul_a = coef_a1_q;
        mul_b = w1_q;
      end
      mbq_pkg::MUL_A2W2: begin
        mul_a = coef_a2_q;
        mul_b = w2_q;
      end
      mbq_pkg::MUL_A0W: begin
        mul_a = coef_a0_q;
        mul_b = w_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = AW'(prod_q);

  // New delay word: input plus rounded feedback, saturated to the state width.
  assign w_sum = AW'(x_q) + (fb_q >>> mbq_pkg::COEF_FRAC_BITS);
  always_comb begin
    if (w_sum > W_MAX) begin
      w_d = W_MAX[SW-1:0];
    end else if (w_sum < W_MIN) begin
      w_d = W_MIN[SW-1:0];
    end else begin
      w_d = w_sum[SW-1:0];
    end
  end

  // Output: rounded sum saturated to the sample width; zero for a clear.
  assign y_sum = ff_q >>> mbq_pkg::COEF_FRAC_BITS;
  always_comb begin
    if ((op_q == mbq_pkg::OP_CLEAR) || !in_range) begin
      y_d = '0;
    end else if (y_sum > Y_MAX) begin
      y_d = Y_MAX[YW-1:0];
    end else if (y_sum < Y_MIN) begin
      y_d = Y_MIN[YW-1:0];
    end else begin
      y_d = y_sum[YW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      chan_q <= chan_i;
      x_q   <= sample_i;
      w1_q  <= in_range_in ? delay_one_q[in_idx] : '0;
      w2_q  <= in_range_in ? delay_two_q[in_idx] : '0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.fb_init) begin
      fb_q <= mbq_pkg::ROUND_HALF + prod_ext;
    end else if (cmd_i.fb_add) begin
      fb_q <= fb_q + prod_ext;
    end
    if (cmd_i.ff_init) begin
      ff_q <= mbq_pkg::ROUND_HALF + prod_ext;
    end else if (cmd_i.ff_add) begin
      ff_q <= ff_q + prod_ext;
    end
    if (cmd_i.w_load) begin
      w_q <= w_d;
    end
    if (cmd_i.finish) begin
      out_chan_q   <= chan_q;
      out_sample_q <= y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mbq_pkg::CHANNELS; i++) begin
        delay_one_q[i] <= '0;
        delay_two_q[i] <= '0;
      end
    end else if (cmd_i.finish && in_range) begin
      if (op_q == mbq_pkg::OP_CLEAR) begin
        delay_one_q[idx] <= '0;
        delay_two_q[idx] <= '0;
      end else begin
        delay_one_q[idx] <= w_q;
        delay_two_q[idx] <= w1_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.op_clear  = (op_q == mbq_pkg::OP_CLEAR);
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_chan_o   = out_chan_q;
  assign out_sample_o = out_sample_q;

  // A finished item never overwrites a beat that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("output register overwritten while stalled");

  // A clear leaves a zero sample and zero delay words behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && (op_q == mbq_pkg::OP_CLEAR) && in_range
      |=> (out_sample_q == '0) && (delay_one_q[$past(idx)] == '0)
          && (delay_two_q[$past(idx)] == '0))
    else $error("clear did not zero the channel");

  // On a filter item the old first delay word moves to the second.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && (op_q == mbq_pkg::OP_FILTER) && in_range
      |=> delay_two_q[$past(idx)] == $past(w1_q))
    else $error("delay words did not shift");

  // Every finished item shows up as a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished item produced no beat");

endmodule

// ===== rtl/multichannel_biquad_df2_top.sv =====
// Top level of the multichannel direct form II biquad: stream ports, the
// configuration write port, controller and datapath. Depends on mbq_pkg,
// mbq_ctrl and mbq_datapath.
//
//   Channel     Dir  Handshake                     Payload
//   s_axis      in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: chan, sample_in
//   m_axis      out  m_axis_tvalid/m_axis_tready   tdata: chan_out, sample_out
//   cfg         in   cfg_we_i (no wait)            cfg_index_i, cfg_data_i
//
// One item is in flight at a time. A filter beat goes from acceptance to
// the output register through the accept state, five products on the single
// shared 32x32 multiplier, an accumulate state and the finish state; a clear
// beat skips the arithmetic. The next beat is accepted in the cycle after the
// result is loaded, even while that result is still waiting on m_axis_tready;
// only a full output register stalls the finish step. Reset clears all delay
// words and loads the coefficient reset values at once, with no clearing pass.
// Coefficients must be written while idle; the block does not enforce it.
module multichannel_biquad_df2_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [mbq_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,  // chan, sample_in
  input  logic                                  s_axis_tuser,  // op
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [mbq_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,  // chan_out, sample_out
  // Coefficient writes.
  input  logic                                  cfg_we_i,
  input  logic [mbq_pkg::REG_BITS-1:0]          cfg_index_i,
  input  logic [mbq_pkg::COEF_BITS-1:0]         cfg_data_i
);

  mbq_pkg::cmd_t cmd;
  mbq_pkg::sts_t sts;

  logic [mbq_pkg::CHAN_BITS-1:0]          in_chan;
  logic signed [mbq_pkg::SAMPLE_BITS-1:0] in_sample;
  logic [mbq_pkg::CHAN_BITS-1:0]          out_chan;
  logic signed [mbq_pkg::SAMPLE_BITS-1:0] out_sample;

  // Unpack the input beat: channel in the low bits, sample above it.
  assign in_chan   = s_axis_tdata[mbq_pkg::CHAN_BITS-1:0];
  assign in_sample = s_axis_tdata[mbq_pkg::CHAN_BITS +: mbq_pkg::SAMPLE_BITS];

  mbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mbq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser),
    .chan_i       (in_chan),
    .sample_i     (in_sample),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_chan_o   (out_chan),
    .out_sample_o (out_sample)
  );

  // Pack the result beat; the pad bits above the sample are zero.
  assign m_axis_tdata = mbq_pkg::OUT_DATA_BITS'({out_sample, out_chan});

endmodule
